FILE: src/jadn_pkg.sv
// shared constants for the joystick axis dead-zone normalizer
// register map, reset values and default widths; no dependencies
package jadn_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 15;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_SEL_BITS  = 3;

    localparam logic [REG_SEL_BITS-1:0] REG_LEFT_EXTREME     = 3'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_ZERO_LEFT_EDGE   = 3'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_ZERO_RIGHT_EDGE  = 3'd2;
    localparam logic [REG_SEL_BITS-1:0] REG_RIGHT_EXTREME    = 3'd3;
    localparam logic [REG_SEL_BITS-1:0] REG_REVERSE_AXIS     = 3'd4;
    localparam logic [REG_SEL_BITS-1:0] REG_CHANGE_THRESHOLD = 3'd5;

    localparam int LEFT_EXTREME_RST     = 0;
    localparam int ZERO_LEFT_EDGE_RST   = 2000;
    localparam int ZERO_RIGHT_EDGE_RST  = 2095;
    localparam int RIGHT_EXTREME_RST    = 4095;
    localparam int CHANGE_THRESHOLD_RST = 328;

endpackage

FILE: src/jadn_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// quotient = (dividend << FRACTION_BITS) / divisor for dividend < divisor
// depends on jadn_pkg for default widths
module jadn_div #(
    parameter int SAMPLE_BITS   = jadn_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = jadn_pkg::FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [SAMPLE_BITS-1:0]   dividend,
    input  logic [SAMPLE_BITS-1:0]   divisor,
    output logic                     done,
    output logic [FRACTION_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]   rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]   dsr_reg, dsr_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;

    logic [SAMPLE_BITS:0]     shifted;
    logic [SAMPLE_BITS:0]     trial;
    logic                     fits;

    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(FRACTION_BITS);
            rem_next  = dividend;
            dsr_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            quo_next = {quo_reg[FRACTION_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/joystick_axis_deadzone_normalizer_core.sv
// joystick axis dead-zone normalizer, top level with apb registers
// depends on jadn_pkg and jadn_div
// flow: a taken sample passes the setup, divide, position and output states, and the
// result is registered once the output is free; no new sample is taken until idle again,
// and the bit-serial divider produces one quotient bit per cycle
// reset: registers take their calibration defaults, last reported position clears to 0
module joystick_axis_deadzone_normalizer_core #(
    parameter int SAMPLE_BITS   = jadn_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = jadn_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jadn_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [jadn_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [jadn_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [SAMPLE_BITS-1:0]              raw_sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [FRACTION_BITS:0]       position,
    output logic                                in_dead_zone,
    output logic                                saturated,
    output logic                                changed
);

    localparam int SB = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_POS   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // configuration registers
    logic [SB-1:0] left_extreme_reg;
    logic [SB-1:0] zero_left_edge_reg;
    logic [SB-1:0] zero_right_edge_reg;
    logic [SB-1:0] right_extreme_reg;
    logic          reverse_axis_reg;
    logic [FB-1:0] change_threshold_reg;

    logic                                 cfg_write;
    logic [jadn_pkg::REG_SEL_BITS-1:0]    reg_sel;

    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[jadn_pkg::APB_ADDR_BITS-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_extreme_reg     <= SB'(jadn_pkg::LEFT_EXTREME_RST);
            zero_left_edge_reg   <= SB'(jadn_pkg::ZERO_LEFT_EDGE_RST);
            zero_right_edge_reg  <= SB'(jadn_pkg::ZERO_RIGHT_EDGE_RST);
            right_extreme_reg    <= SB'(jadn_pkg::RIGHT_EXTREME_RST);
            reverse_axis_reg     <= 1'b1;
            change_threshold_reg <= FB'(jadn_pkg::CHANGE_THRESHOLD_RST);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                jadn_pkg::REG_LEFT_EXTREME:     left_extreme_reg     <= pwdata[SB-1:0];
                jadn_pkg::REG_ZERO_LEFT_EDGE:   zero_left_edge_reg   <= pwdata[SB-1:0];
                jadn_pkg::REG_ZERO_RIGHT_EDGE:  zero_right_edge_reg  <= pwdata[SB-1:0];
                jadn_pkg::REG_RIGHT_EXTREME:    right_extreme_reg    <= pwdata[SB-1:0];
                jadn_pkg::REG_REVERSE_AXIS:     reverse_axis_reg     <= pwdata[0];
                jadn_pkg::REG_CHANGE_THRESHOLD: change_threshold_reg <= pwdata[FB-1:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            jadn_pkg::REG_LEFT_EXTREME:     prdata = jadn_pkg::APB_DATA_BITS'(left_extreme_reg);
            jadn_pkg::REG_ZERO_LEFT_EDGE:   prdata = jadn_pkg::APB_DATA_BITS'(zero_left_edge_reg);
            jadn_pkg::REG_ZERO_RIGHT_EDGE:  prdata = jadn_pkg::APB_DATA_BITS'(zero_right_edge_reg);
            jadn_pkg::REG_RIGHT_EXTREME:    prdata = jadn_pkg::APB_DATA_BITS'(right_extreme_reg);
            jadn_pkg::REG_REVERSE_AXIS:     prdata = jadn_pkg::APB_DATA_BITS'(reverse_axis_reg);
            jadn_pkg::REG_CHANGE_THRESHOLD: prdata = jadn_pkg::APB_DATA_BITS'(change_threshold_reg);
            default:                        prdata = '0;
        endcase
    end

    // control
    logic [2:0] state_reg, state_next;
    logic       sample_take;
    logic       out_free;

    assign sample_take = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign out_free    = !result_valid || !result_stall;

    // operand setup from the held sample
    logic [SB-1:0] s_reg;
    logic          right_side;
    logic          left_side;
    logic [SB-1:0] num_mag;
    logic [SB:0]   den_s;
    logic [SB:0]   den_neg_s;
    logic [SB-1:0] den_mag;
    logic          setup_dz;
    logic          setup_zero;
    logic          setup_over;

    assign right_side = (s_reg > zero_right_edge_reg);
    assign left_side  = (s_reg < zero_left_edge_reg);
    assign num_mag    = right_side ? (s_reg - zero_right_edge_reg)
                                   : (zero_left_edge_reg - s_reg);
    assign den_s      = right_side ? ({1'b0, right_extreme_reg} - {1'b0, zero_right_edge_reg})
                                   : ({1'b0, left_extreme_reg} - {1'b0, zero_left_edge_reg});
    assign den_neg_s  = -den_s;
    assign den_mag    = den_s[SB] ? den_neg_s[SB-1:0] : den_s[SB-1:0];
    assign setup_dz   = !right_side && !left_side;
    assign setup_zero = (den_mag == '0);
    assign setup_over = (num_mag > den_mag);

    logic dz_reg;
    logic zero_reg;
    logic sat_reg;
    logic max_reg;
    logic neg_reg;

    // divider
    logic          div_start;
    logic          div_done;
    logic [FB-1:0] div_quo;

    assign div_start = (state_reg == ST_SETUP);

    jadn_div #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (den_mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    // signed position
    logic [FB-1:0]        mag;
    logic signed [FB:0]   pos_calc;
    logic signed [FB:0]   pos_reg;

    assign mag      = max_reg ? {FB{1'b1}} : div_quo;
    assign pos_calc = (dz_reg || zero_reg) ? '0
                    : (neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));

    // change test against the last reported position
    logic signed [FB:0]   last_reg;
    logic signed [FB+1:0] diff;
    logic signed [FB+1:0] diff_neg;
    logic [FB+1:0]        diff_abs;
    logic                 chg;

    assign diff     = {pos_reg[FB], pos_reg} - {last_reg[FB], last_reg};
    assign diff_neg = -diff;
    assign diff_abs = diff[FB+1] ? diff_neg : diff;
    assign chg      = (diff_abs >= {2'b00, change_threshold_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (sample_take) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_POS;
            ST_POS:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic                 out_valid_reg;
    logic signed [FB:0]   out_pos_reg;
    logic                 out_dz_reg;
    logic                 out_sat_reg;
    logic                 out_chg_reg;
    logic                 out_load;

    assign out_load = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            if (out_load && chg)
                last_reg <= pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
            s_reg <= raw_sample;
        if (state_reg == ST_SETUP)
        begin
            dz_reg   <= setup_dz;
            zero_reg <= setup_zero;
            sat_reg  <= !setup_dz && (setup_zero || setup_over);
            max_reg  <= (num_mag >= den_mag);
            neg_reg  <= reverse_axis_reg ^ den_s[SB];
        end
        if (state_reg == ST_POS)
            pos_reg <= pos_calc;
        if (out_load)
        begin
            out_pos_reg <= pos_reg;
            out_dz_reg  <= dz_reg;
            out_sat_reg <= sat_reg;
            out_chg_reg <= chg;
        end
    end

    assign result_valid = out_valid_reg;
    assign position     = out_pos_reg;
    assign in_dead_zone = out_dz_reg;
    assign saturated    = out_sat_reg;
    assign changed      = out_chg_reg;

endmodule
